// ===== rtl/gray_scott_stencil_step_top_defines.svh =====
// assertion macros used by the result queue
`ifndef GRAY_SCOTT_STENCIL_STEP_TOP_DEFINES_SVH
`define GRAY_SCOTT_STENCIL_STEP_TOP_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define GSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gss: same-cycle check failed");
// next-cycle implication
`define GSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gss: next-cycle check failed");
`else
`define GSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/gss_pkg.sv =====
package gss_pkg;

    localparam int DATA_BITS     = 32;
    localparam int FRAC_BITS     = 24;
    localparam int MAX_ROW_WIDTH = 1024;
    localparam int REG_BITS      = 31;
    localparam int WIDTH_BITS    = 11;
    localparam int FIFO_DEPTH    = 16;
    localparam int DP_STAGES     = 7;
    localparam int ADDR_BITS     = 5;

    typedef logic signed [DATA_BITS-1:0]   data_t;
    typedef logic signed [2*DATA_BITS-1:0] wide_t;

    // register indexes
    localparam logic [2:0] REG_TIME_STEP   = 3'd0;
    localparam logic [2:0] REG_DIFFUSION_U = 3'd1;
    localparam logic [2:0] REG_DIFFUSION_V = 3'd2;
    localparam logic [2:0] REG_FEED_RATE   = 3'd3;
    localparam logic [2:0] REG_KILL_RATE   = 3'd4;
    localparam logic [2:0] REG_INV_DX_SQ   = 3'd5;
    localparam logic [2:0] REG_INV_DY_SQ   = 3'd6;
    localparam logic [2:0] REG_ROW_WIDTH   = 3'd7;

    // reset values
    localparam logic [REG_BITS-1:0]   RST_TIME_STEP   = 31'd16777216;
    localparam logic [REG_BITS-1:0]   RST_DIFFUSION_U = 31'd3355443;
    localparam logic [REG_BITS-1:0]   RST_DIFFUSION_V = 31'd1677721;
    localparam logic [REG_BITS-1:0]   RST_FEED_RATE   = 31'd922746;
    localparam logic [REG_BITS-1:0]   RST_KILL_RATE   = 31'd1040187;
    localparam logic [REG_BITS-1:0]   RST_INV_DX_SQ   = 31'd16777216;
    localparam logic [REG_BITS-1:0]   RST_INV_DY_SQ   = 31'd16777216;
    localparam logic [WIDTH_BITS-1:0] RST_ROW_WIDTH   = 11'd256;

    // per-item control that travels with the data
    typedef struct packed {
        logic has_lag;
        logic border;
        logic lr;
        logic fend;
    } ctrl_t;

    // five-point neighbourhood of one field
    typedef struct packed {
        data_t up;
        data_t left;
        data_t ctr;
        data_t right;
        data_t down;
    } win_t;

    // results of one item: lagged cell and last-row cell
    typedef struct packed {
        logic  has_lag;
        data_t lag_u;
        data_t lag_v;
        logic  has_thru;
        data_t thru_u;
        data_t thru_v;
        logic  fend;
    } pair_t;

    function automatic wide_t ext(input data_t x);
        return wide_t'(x);
    endfunction

    function automatic data_t sat(input wide_t x);
        wide_t maxv;
        wide_t minv;
        maxv = {{(DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
        minv = ~maxv;
        if (x > maxv) begin
            return data_t'(maxv);
        end
        if (x < minv) begin
            return data_t'(minv);
        end
        return data_t'(x);
    endfunction

    // fixed-point product, floor shift, saturated
    function automatic data_t mulq(input data_t a, input data_t b);
        wide_t p;
        p = ext(a) * ext(b);
        p = p >>> FRAC_BITS;
        return sat(p);
    endfunction

endpackage

// ===== rtl/gss_window.sv =====
module gss_window #(
    parameter int MAX_ROW_WIDTH = gss_pkg::MAX_ROW_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_fire,
    input  gss_pkg::data_t                   u_value,
    input  gss_pkg::data_t                   v_value,
    input  logic                             frame_start,
    input  logic                             last_row,
    input  logic [gss_pkg::WIDTH_BITS-1:0]   row_width,
    output logic                             win_valid,
    output gss_pkg::win_t                    u_win,
    output gss_pkg::win_t                    v_win,
    output gss_pkg::ctrl_t                   win_ctrl
);

    localparam int CW = $clog2(MAX_ROW_WIDTH);
    localparam int DB = gss_pkg::DATA_BITS;

    logic [CW-1:0] col_reg, col_next;
    logic [1:0]    row_reg, row_next;
    logic [CW-1:0] c, addr_r;
    logic [1:0]    r;
    logic [15:0]   w;
    logic          last_col;
    gss_pkg::ctrl_t ctrl_next;

    logic [2*DB-1:0] recent_mem [MAX_ROW_WIDTH];
    logic [2*DB-1:0] older_mem  [MAX_ROW_WIDTH];

    logic [2*DB-1:0] ctr_rd_reg, right_rd_reg, up_rd_reg, left_reg, down_reg;
    logic [CW-1:0]   addr1_reg;
    gss_pkg::ctrl_t  ctrl_reg;
    logic            win_valid_reg;

    // column position, width clamp and border decode
    always_comb
    begin
        c = frame_start ? '0 : col_reg;
        r = frame_start ? '0 : row_reg;
        if (row_width < 11'd3)
        begin
            w = 16'd3;
        end
        else if (32'(row_width) > MAX_ROW_WIDTH)
        begin
            w = 16'(MAX_ROW_WIDTH);
        end
        else
        begin
            w = 16'(row_width);
        end
        last_col = 16'(c) >= (w - 16'd1);
        ctrl_next.has_lag = (r != 2'd0);
        ctrl_next.border  = (r == 2'd1) || (c == '0) || last_col;
        ctrl_next.lr      = last_row;
        ctrl_next.fend    = last_col & last_row;
        addr_r = (32'(c) == MAX_ROW_WIDTH - 1) ? '0 : c + 1'b1;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? 2'd0 : ((r == 2'd2) ? 2'd2 : r + 2'd1);
        end
        else
        begin
            col_next = c + 1'b1;
            row_next = r;
        end
    end

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            win_valid_reg <= in_fire;
            if (in_fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // row buffers: read before write, older row filled from the recent read
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ctr_rd_reg      <= recent_mem[c];
            right_rd_reg    <= recent_mem[addr_r];
            up_rd_reg       <= older_mem[c];
            recent_mem[c]   <= {u_value, v_value};
            down_reg        <= {u_value, v_value};
            addr1_reg       <= c;
            ctrl_reg        <= ctrl_next;
        end
        if (win_valid_reg)
        begin
            older_mem[addr1_reg] <= ctr_rd_reg;
            left_reg             <= ctr_rd_reg;
        end
    end

    assign win_valid   = win_valid_reg;
    assign win_ctrl    = ctrl_reg;
    assign u_win.up    = up_rd_reg[2*DB-1:DB];
    assign u_win.left  = left_reg[2*DB-1:DB];
    assign u_win.ctr   = ctr_rd_reg[2*DB-1:DB];
    assign u_win.right = right_rd_reg[2*DB-1:DB];
    assign u_win.down  = down_reg[2*DB-1:DB];
    assign v_win.up    = up_rd_reg[DB-1:0];
    assign v_win.left  = left_reg[DB-1:0];
    assign v_win.ctr   = ctr_rd_reg[DB-1:0];
    assign v_win.right = right_rd_reg[DB-1:0];
    assign v_win.down  = down_reg[DB-1:0];

endmodule

// ===== rtl/gss_datapath.sv =====
module gss_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               win_valid,
    input  gss_pkg::win_t                      u_win,
    input  gss_pkg::win_t                      v_win,
    input  gss_pkg::ctrl_t                     win_ctrl,
    input  logic [gss_pkg::REG_BITS-1:0]       time_step,
    input  logic [gss_pkg::REG_BITS-1:0]       diffusion_u,
    input  logic [gss_pkg::REG_BITS-1:0]       diffusion_v,
    input  logic [gss_pkg::REG_BITS-1:0]       feed_rate,
    input  logic [gss_pkg::REG_BITS-1:0]       kill_rate,
    input  logic [gss_pkg::REG_BITS-1:0]       inv_dx_squared,
    input  logic [gss_pkg::REG_BITS-1:0]       inv_dy_squared,
    output logic                               res_valid,
    output gss_pkg::pair_t                     res,
    output logic [gss_pkg::DP_STAGES-1:0]      stage_valid
);

    typedef struct packed {
        gss_pkg::data_t uc;
        gss_pkg::data_t vc;
        gss_pkg::data_t su;
        gss_pkg::data_t sv;
        gss_pkg::ctrl_t ctrl;
    } carry_t;

    gss_pkg::data_t dt, du_k, dv_k, fr, kr, idx, idy, one;

    logic [gss_pkg::DP_STAGES-1:0] vld_reg;
    carry_t car_reg [gss_pkg::DP_STAGES-1];

    gss_pkg::data_t d2xu_reg, d2yu_reg, d2xv_reg, d2yv_reg;
    gss_pkg::data_t pxu_reg, pyu_reg, pxv_reg, pyv_reg, uv_reg, onemu_reg, fk_reg;
    gss_pkg::data_t lapu_reg, lapv_reg, uvv_reg, onemu3_reg, fk3_reg;
    gss_pkg::data_t au_reg, bu_reg, av_reg, bv_reg, uvv4_reg;
    gss_pkg::data_t du_reg, dv_reg;
    gss_pkg::data_t tu_reg, tv_reg;
    gss_pkg::pair_t res_reg;

    assign dt   = {1'b0, time_step};
    assign du_k = {1'b0, diffusion_u};
    assign dv_k = {1'b0, diffusion_v};
    assign fr   = {1'b0, feed_rate};
    assign kr   = {1'b0, kill_rate};
    assign idx  = {1'b0, inv_dx_squared};
    assign idy  = {1'b0, inv_dy_squared};
    assign one  = gss_pkg::data_t'(64'sd1 <<< gss_pkg::FRAC_BITS);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[gss_pkg::DP_STAGES-2:0], win_valid};
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        // second differences
        d2xu_reg <= gss_pkg::sat(gss_pkg::ext(u_win.left) + gss_pkg::ext(u_win.right)
                    - (gss_pkg::ext(u_win.ctr) <<< 1));
        d2yu_reg <= gss_pkg::sat(gss_pkg::ext(u_win.up) + gss_pkg::ext(u_win.down)
                    - (gss_pkg::ext(u_win.ctr) <<< 1));
        d2xv_reg <= gss_pkg::sat(gss_pkg::ext(v_win.left) + gss_pkg::ext(v_win.right)
                    - (gss_pkg::ext(v_win.ctr) <<< 1));
        d2yv_reg <= gss_pkg::sat(gss_pkg::ext(v_win.up) + gss_pkg::ext(v_win.down)
                    - (gss_pkg::ext(v_win.ctr) <<< 1));
        car_reg[0] <= '{uc: u_win.ctr, vc: v_win.ctr, su: u_win.down, sv: v_win.down,
                        ctrl: win_ctrl};

        // axis scaling, u*v, feed terms
        pxu_reg   <= gss_pkg::mulq(d2xu_reg, idx);
        pyu_reg   <= gss_pkg::mulq(d2yu_reg, idy);
        pxv_reg   <= gss_pkg::mulq(d2xv_reg, idx);
        pyv_reg   <= gss_pkg::mulq(d2yv_reg, idy);
        uv_reg    <= gss_pkg::mulq(car_reg[0].uc, car_reg[0].vc);
        onemu_reg <= gss_pkg::sat(gss_pkg::ext(one) - gss_pkg::ext(car_reg[0].uc));
        fk_reg    <= gss_pkg::sat(gss_pkg::ext(fr) + gss_pkg::ext(kr));

        // laplacians and uvv
        lapu_reg   <= gss_pkg::sat(gss_pkg::ext(pxu_reg) + gss_pkg::ext(pyu_reg));
        lapv_reg   <= gss_pkg::sat(gss_pkg::ext(pxv_reg) + gss_pkg::ext(pyv_reg));
        uvv_reg    <= gss_pkg::mulq(uv_reg, car_reg[1].vc);
        onemu3_reg <= onemu_reg;
        fk3_reg    <= fk_reg;

        // rate products
        au_reg   <= gss_pkg::mulq(du_k, lapu_reg);
        bu_reg   <= gss_pkg::mulq(fr, onemu3_reg);
        av_reg   <= gss_pkg::mulq(dv_k, lapv_reg);
        bv_reg   <= gss_pkg::mulq(fk3_reg, car_reg[2].vc);
        uvv4_reg <= uvv_reg;

        // derivatives
        du_reg <= gss_pkg::sat(gss_pkg::ext(au_reg) - gss_pkg::ext(uvv4_reg)
                  + gss_pkg::ext(bu_reg));
        dv_reg <= gss_pkg::sat(gss_pkg::ext(av_reg) + gss_pkg::ext(uvv4_reg)
                  - gss_pkg::ext(bv_reg));

        // time step
        tu_reg <= gss_pkg::mulq(dt, du_reg);
        tv_reg <= gss_pkg::mulq(dt, dv_reg);

        // euler update or border pass-through
        res_reg.has_lag  <= car_reg[5].ctrl.has_lag;
        res_reg.lag_u    <= car_reg[5].ctrl.border ? car_reg[5].uc
                            : gss_pkg::sat(gss_pkg::ext(car_reg[5].uc) + gss_pkg::ext(tu_reg));
        res_reg.lag_v    <= car_reg[5].ctrl.border ? car_reg[5].vc
                            : gss_pkg::sat(gss_pkg::ext(car_reg[5].vc) + gss_pkg::ext(tv_reg));
        res_reg.has_thru <= car_reg[5].ctrl.lr;
        res_reg.thru_u   <= car_reg[5].su;
        res_reg.thru_v   <= car_reg[5].sv;
        res_reg.fend     <= car_reg[5].ctrl.fend;

        for (int i = 1; i < gss_pkg::DP_STAGES - 1; i++)
        begin
            car_reg[i] <= car_reg[i-1];
        end
    end

    assign res_valid   = vld_reg[gss_pkg::DP_STAGES-1];
    assign res         = res_reg;
    assign stage_valid = vld_reg;

endmodule

// ===== rtl/gss_res_fifo.sv =====
`include "gray_scott_stencil_step_top_defines.svh"

module gss_res_fifo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  gss_pkg::pair_t                     push_data,
    output logic [$clog2(gss_pkg::FIFO_DEPTH+1)-1:0] count,
    output logic                               out_valid,
    input  logic                               out_ready,
    output gss_pkg::data_t                     u_next,
    output gss_pkg::data_t                     v_next,
    output logic                               frame_end,
    output logic                               run_last
);

    localparam int PW   = $clog2(gss_pkg::FIFO_DEPTH);
    localparam int CNTW = $clog2(gss_pkg::FIFO_DEPTH + 1);

    gss_pkg::pair_t mem_reg [gss_pkg::FIFO_DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [CNTW-1:0] count_reg, count_next;
    logic            sent_reg, sent_next;
    gss_pkg::pair_t  head;
    logic            push_en, show_lag, fire, pop;

    // head selection: lagged cell first, then the last-row cell
    always_comb
    begin
        head      = mem_reg[rd_reg];
        push_en   = push & (push_data.has_lag | push_data.has_thru);
        show_lag  = head.has_lag & ~sent_reg;
        out_valid = (count_reg != '0);
        u_next    = show_lag ? head.lag_u : head.thru_u;
        v_next    = show_lag ? head.lag_v : head.thru_v;
        frame_end = show_lag ? 1'b0 : head.fend;
        run_last  = show_lag ? ~head.has_thru : 1'b1;
        fire      = out_valid & out_ready;
        pop       = fire & (~show_lag | ~head.has_thru);
        sent_next = pop ? 1'b0 : (fire ? 1'b1 : sent_reg);
        count_next = count_reg + CNTW'(push_en) - CNTW'(pop);
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
            sent_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sent_reg  <= sent_next;
            if (push_en)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign count = count_reg;

    `GSS_ASSERT_IMP(a_no_overflow, clk, rst_n, push_en, count_reg < CNTW'(gss_pkg::FIFO_DEPTH))
    `GSS_ASSERT_NXT(a_fill_up, clk, rst_n, push_en && !pop, count_reg == CNTW'($past(count_reg) + 1'b1))
    `GSS_ASSERT_IMP(a_sent_pair, clk, rst_n, sent_reg, out_valid && head.has_lag && head.has_thru)

endmodule

// ===== rtl/gray_scott_stencil_step_top.sv =====
// an item goes through window registers, datapath pipeline and result queue to the output
// a cell's updated value appears with the item of the row below; last-row items add their own
// throughput: one item per cycle while in_ready is high; one result per cycle while out_ready
// credit on the 16-entry result queue holds in_ready low once it could fill
// reset: counters, valid bits and queue cleared, registers to defaults; row buffers not cleared
module gray_scott_stencil_step_top #(
    parameter int MAX_ROW_WIDTH = gss_pkg::MAX_ROW_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gss_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  gss_pkg::data_t                   u_value,
    input  gss_pkg::data_t                   v_value,
    input  logic                             frame_start,
    input  logic                             last_row,
    output logic                             out_valid,
    input  logic                             out_ready,
    output gss_pkg::data_t                   u_next,
    output gss_pkg::data_t                   v_next,
    output logic                             frame_end,
    output logic                             run_last
);

    localparam int CNTW = $clog2(gss_pkg::FIFO_DEPTH + 1);

    logic [gss_pkg::REG_BITS-1:0]   ts_reg, du_reg, dv_reg, fr_reg, kr_reg, idx_reg, idy_reg;
    logic [gss_pkg::WIDTH_BITS-1:0] rw_reg;
    logic                           wr_en, in_fire, win_valid, res_valid;
    gss_pkg::win_t                  u_win, v_win;
    gss_pkg::ctrl_t                 win_ctrl;
    gss_pkg::pair_t                 res;
    logic [gss_pkg::DP_STAGES-1:0]  stage_valid;
    logic [CNTW-1:0]                fifo_count;
    logic [CNTW:0]                  committed;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg  <= gss_pkg::RST_TIME_STEP;
            du_reg  <= gss_pkg::RST_DIFFUSION_U;
            dv_reg  <= gss_pkg::RST_DIFFUSION_V;
            fr_reg  <= gss_pkg::RST_FEED_RATE;
            kr_reg  <= gss_pkg::RST_KILL_RATE;
            idx_reg <= gss_pkg::RST_INV_DX_SQ;
            idy_reg <= gss_pkg::RST_INV_DY_SQ;
            rw_reg  <= gss_pkg::RST_ROW_WIDTH;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                gss_pkg::REG_TIME_STEP:   ts_reg  <= pwdata[gss_pkg::REG_BITS-1:0];
                gss_pkg::REG_DIFFUSION_U: du_reg  <= pwdata[gss_pkg::REG_BITS-1:0];
                gss_pkg::REG_DIFFUSION_V: dv_reg  <= pwdata[gss_pkg::REG_BITS-1:0];
                gss_pkg::REG_FEED_RATE:   fr_reg  <= pwdata[gss_pkg::REG_BITS-1:0];
                gss_pkg::REG_KILL_RATE:   kr_reg  <= pwdata[gss_pkg::REG_BITS-1:0];
                gss_pkg::REG_INV_DX_SQ:   idx_reg <= pwdata[gss_pkg::REG_BITS-1:0];
                gss_pkg::REG_INV_DY_SQ:   idy_reg <= pwdata[gss_pkg::REG_BITS-1:0];
                gss_pkg::REG_ROW_WIDTH:   rw_reg  <= pwdata[gss_pkg::WIDTH_BITS-1:0];
                default:                  ts_reg  <= ts_reg;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        unique case (paddr[4:2])
            gss_pkg::REG_TIME_STEP:   prdata = {1'b0, ts_reg};
            gss_pkg::REG_DIFFUSION_U: prdata = {1'b0, du_reg};
            gss_pkg::REG_DIFFUSION_V: prdata = {1'b0, dv_reg};
            gss_pkg::REG_FEED_RATE:   prdata = {1'b0, fr_reg};
            gss_pkg::REG_KILL_RATE:   prdata = {1'b0, kr_reg};
            gss_pkg::REG_INV_DX_SQ:   prdata = {1'b0, idx_reg};
            gss_pkg::REG_INV_DY_SQ:   prdata = {1'b0, idy_reg};
            gss_pkg::REG_ROW_WIDTH:   prdata = {21'd0, rw_reg};
            default:                  prdata = '0;
        endcase
    end

    // queue credit: every item in flight holds one entry
    assign committed = (CNTW+1)'(fifo_count) + (CNTW+1)'(win_valid)
                     + (CNTW+1)'($countones(stage_valid));
    assign in_ready  = committed < (CNTW+1)'(gss_pkg::FIFO_DEPTH);
    assign in_fire   = in_valid & in_ready;

    gss_window #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .u_value     (u_value),
        .v_value     (v_value),
        .frame_start (frame_start),
        .last_row    (last_row),
        .row_width   (rw_reg),
        .win_valid   (win_valid),
        .u_win       (u_win),
        .v_win       (v_win),
        .win_ctrl    (win_ctrl)
    );

    gss_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .win_valid      (win_valid),
        .u_win          (u_win),
        .v_win          (v_win),
        .win_ctrl       (win_ctrl),
        .time_step      (ts_reg),
        .diffusion_u    (du_reg),
        .diffusion_v    (dv_reg),
        .feed_rate      (fr_reg),
        .kill_rate      (kr_reg),
        .inv_dx_squared (idx_reg),
        .inv_dy_squared (idy_reg),
        .res_valid      (res_valid),
        .res            (res),
        .stage_valid    (stage_valid)
    );

    gss_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .count     (fifo_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .u_next    (u_next),
        .v_next    (v_next),
        .frame_end (frame_end),
        .run_last  (run_last)
    );

endmodule

// ===== verif/tb.sv =====
module tb;

    // one emitted cell as seen on the output
    typedef struct {
        gss_pkg::data_t u;
        gss_pkg::data_t v;
        bit             fend;
        bit             rlast;
    } cell_out_t;

    // stencil predictor and store of expected cells
    class stencil_board;
        longint    cfg [8];
        longint    u_old [gss_pkg::MAX_ROW_WIDTH];
        longint    u_new [gss_pkg::MAX_ROW_WIDTH];
        longint    v_old [gss_pkg::MAX_ROW_WIDTH];
        longint    v_new [gss_pkg::MAX_ROW_WIDTH];
        int        col;
        int        row;
        cell_out_t expected [$];
        int        errors;

        function void clear();
            cfg[gss_pkg::REG_TIME_STEP]   = gss_pkg::RST_TIME_STEP;
            cfg[gss_pkg::REG_DIFFUSION_U] = gss_pkg::RST_DIFFUSION_U;
            cfg[gss_pkg::REG_DIFFUSION_V] = gss_pkg::RST_DIFFUSION_V;
            cfg[gss_pkg::REG_FEED_RATE]   = gss_pkg::RST_FEED_RATE;
            cfg[gss_pkg::REG_KILL_RATE]   = gss_pkg::RST_KILL_RATE;
            cfg[gss_pkg::REG_INV_DX_SQ]   = gss_pkg::RST_INV_DX_SQ;
            cfg[gss_pkg::REG_INV_DY_SQ]   = gss_pkg::RST_INV_DY_SQ;
            cfg[gss_pkg::REG_ROW_WIDTH]   = gss_pkg::RST_ROW_WIDTH;
            foreach (u_old[i])
            begin
                u_old[i] = 0;
                u_new[i] = 0;
                v_old[i] = 0;
                v_new[i] = 0;
            end
            col    = 0;
            row    = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            if (idx == gss_pkg::REG_ROW_WIDTH)
                cfg[idx] = val[gss_pkg::WIDTH_BITS-1:0];
            else
                cfg[idx] = val[gss_pkg::REG_BITS-1:0];
        endfunction

        function int eff_width();
            if (cfg[gss_pkg::REG_ROW_WIDTH] < 3)
                return 3;
            if (cfg[gss_pkg::REG_ROW_WIDTH] > gss_pkg::MAX_ROW_WIDTH)
                return gss_pkg::MAX_ROW_WIDTH;
            return int'(cfg[gss_pkg::REG_ROW_WIDTH]);
        endfunction

        function longint clip(longint x);
            if (x > 64'sh7FFFFFFF)
                return 64'sh7FFFFFFF;
            if (x < -64'sh80000000)
                return -64'sh80000000;
            return x;
        endfunction

        // q8.24 product, floor, saturated
        function longint qmul(longint a, longint b);
            longint p;
            p = a * b;
            return clip(p >>> gss_pkg::FRAC_BITS);
        endfunction

        function longint lap(longint up, longint lf, longint ctr, longint rt, longint dn);
            longint dx;
            longint dy;
            dx = clip(lf + rt - 2 * ctr);
            dy = clip(up + dn - 2 * ctr);
            return clip(qmul(dx, cfg[gss_pkg::REG_INV_DX_SQ])
                        + qmul(dy, cfg[gss_pkg::REG_INV_DY_SQ]));
        endfunction

        function void add_cell(longint u, longint v, bit fe);
            cell_out_t e;
            e.u     = gss_pkg::data_t'(u);
            e.v     = gss_pkg::data_t'(v);
            e.fend  = fe;
            e.rlast = 0;
            expected = {expected, e};
        endfunction

        function void note_input(gss_pkg::data_t ui, gss_pkg::data_t vi, bit fs, bit lr);
            longint u, v, uc, vc, lu, lv, uvv, fk, omu, du, dv, f;
            int     w, c, n0;
            bit     lc;
            u  = ui;
            v  = vi;
            n0 = expected.size();
            if (fs)
            begin
                col = 0;
                row = 0;
            end
            w  = eff_width();
            c  = (col >= gss_pkg::MAX_ROW_WIDTH) ? gss_pkg::MAX_ROW_WIDTH - 1 : col;
            lc = c >= w - 1;
            // lagged cell of the row above
            if (row > 0)
            begin
                uc = u_new[c];
                vc = v_new[c];
                if (row == 1 || c == 0 || lc)
                    add_cell(uc, vc, 0);
                else
                begin
                    f   = cfg[gss_pkg::REG_FEED_RATE];
                    lu  = lap(u_old[c], u_old[c-1], uc, u_new[c+1], u);
                    lv  = lap(v_old[c], v_old[c-1], vc, v_new[c+1], v);
                    uvv = qmul(qmul(uc, vc), vc);
                    fk  = clip(f + cfg[gss_pkg::REG_KILL_RATE]);
                    omu = clip((64'sd1 << gss_pkg::FRAC_BITS) - uc);
                    du  = clip(qmul(cfg[gss_pkg::REG_DIFFUSION_U], lu) - uvv + qmul(f, omu));
                    dv  = clip(qmul(cfg[gss_pkg::REG_DIFFUSION_V], lv) + uvv - qmul(fk, vc));
                    add_cell(clip(uc + qmul(cfg[gss_pkg::REG_TIME_STEP], du)),
                             clip(vc + qmul(cfg[gss_pkg::REG_TIME_STEP], dv)), 0);
                end
            end
            u_old[c] = u_new[c];
            v_old[c] = v_new[c];
            u_new[c] = u;
            v_new[c] = v;
            // last row passes straight through
            if (lr)
                add_cell(u, v, lc);
            if (expected.size() > n0)
                expected[expected.size()-1].rlast = 1;
            if (lc)
            begin
                col = 0;
                if (lr)
                    row = 0;
                else if (row < 16'hFFFF)
                    row++;
            end
            else
                col = c + 1;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(gss_pkg::data_t u, gss_pkg::data_t v, bit fe, bit rl);
            cell_out_t e;
            if (expected.size() == 0)
            begin
                report($sformatf("unexpected cell u=%h v=%h", u, v));
                return;
            end
            e = expected.pop_front();
            if (u !== e.u)
                report($sformatf("u_next %h, want %h", u, e.u));
            if (v !== e.v)
                report($sformatf("v_next %h, want %h", v, e.v));
            if (fe !== e.fend)
                report($sformatf("frame_end %b, want %b", fe, e.fend));
            if (rl !== e.rlast)
                report($sformatf("run_last %b, want %b", rl, e.rlast));
        endtask

        function bit busy();
            return expected.size() != 0;
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [gss_pkg::ADDR_BITS-1:0]  paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_ready;
    gss_pkg::data_t                 u_value;
    gss_pkg::data_t                 v_value;
    logic                           frame_start;
    logic                           last_row;
    logic                           out_valid;
    logic                           out_ready;
    gss_pkg::data_t                 u_next;
    gss_pkg::data_t                 v_next;
    logic                           frame_end;
    logic                           run_last;

    stencil_board board;
    int           burst_left;
    int           cells_sent;
    int           quiet_cycles;

    gray_scott_stencil_step_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .u_value     (u_value),
        .v_value     (v_value),
        .frame_start (frame_start),
        .last_row    (last_row),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .u_next      (u_next),
        .v_next      (v_next),
        .frame_end   (frame_end),
        .run_last    (run_last)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // receiver stall pattern: free, patchy or mostly stalled stretches
    int stall_mode;
    int stall_left;
    initial
    begin
        out_ready  = 1'b0;
        stall_mode = 0;
        stall_left = 0;
    end
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 150);
        end
        stall_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(u_next, v_next, frame_end, run_last);
    end

    // watchdog on accepted items and taken results
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 20000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // setup and access phase, then the bus goes idle
    task cfg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, val);
        @(posedge clk);
    endtask

    // drop valid and let the block drain
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.busy())
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task send_cell(gss_pkg::data_t u, gss_pkg::data_t v, bit fs, bit lr);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 25);
        end
        in_valid    <= 1'b1;
        u_value     <= u;
        v_value     <= v;
        frame_start <= fs;
        last_row    <= lr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_input(u, v, fs, lr);
        burst_left--;
        cells_sent++;
    endtask

    function gss_pkg::data_t pick_value(int kind);
        case (kind)
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 0;
            3: return 32'sh01000000;
            4, 5: return $urandom;
            6: return -$signed($urandom_range(0, 1 << 25));
            default: return $urandom_range(0, 1 << 25);
        endcase
    endfunction

    // one grid pass of full rows; may be cut short or carry stray last-row flags
    task send_frame(int rows, bit noisy, bit cut, int kind);
        int w, total, stop, r;
        bit lr;
        w     = board.eff_width();
        total = rows * w;
        stop  = cut ? $urandom_range(1, total - 1) : total;
        for (int i = 0; i < stop; i++)
        begin
            r  = i / w;
            lr = (r == rows - 1) || (noisy && $urandom_range(0, 19) == 0);
            send_cell(pick_value(kind < 0 ? $urandom_range(0, 9) : (kind + i) % 4),
                      pick_value(kind < 0 ? $urandom_range(0, 9) : (kind + i + 1) % 4),
                      i == 0, lr);
        end
    endtask

    function logic [31:0] pick_reg();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 32'h7FFFFFFF;
            2: return $urandom;
            default: return $urandom_range(0, 1 << 24);
        endcase
    endfunction

    initial
    begin
        board = new();
        board.clear();
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        u_value     = '0;
        v_value     = '0;
        frame_start = 1'b0;
        last_row    = 1'b0;
        burst_left  = 0;
        cells_sent  = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every register at its top, narrowest grid, extreme cells
        for (int i = 0; i < 7; i++)
            cfg_write(i[2:0], 32'hFFFFFFFF);
        cfg_write(gss_pkg::REG_ROW_WIDTH, 3);
        send_frame(3, 0, 0, 0);
        drain();
        // all rates zero, width below range clamps to three
        for (int i = 0; i < 7; i++)
            cfg_write(i[2:0], 0);
        cfg_write(gss_pkg::REG_ROW_WIDTH, 0);
        send_frame(3, 0, 0, 2);
        send_frame(1, 0, 0, 1);
        send_frame(2, 0, 1, 3);
        drain();

        // widest grid, one row only
        cfg_write(gss_pkg::REG_ROW_WIDTH, 32'h7FF);
        send_frame(1, 0, 0, -1);
        drain();

        // random phases
        while (cells_sent < 1200)
        begin
            for (int i = 0; i < 7; i++)
                cfg_write(i[2:0], ($urandom_range(0, 2) == 0) ? pick_reg()
                                                                : $urandom_range(0, 1 << 22));
            cfg_write(gss_pkg::REG_ROW_WIDTH, ($urandom_range(0, 7) == 0)
                                              ? $urandom_range(0, 2)
                                              : $urandom_range(3, 24));
            repeat ($urandom_range(1, 4))
                send_frame($urandom_range(1, 6), $urandom_range(0, 5) == 0,
                           $urandom_range(0, 7) == 0, -1);
            drain();
        end

        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
